[sv/half_duplex_packet_link_macros.svh]
// Assertion macros for the half-duplex packet link.
// Included by hdpl_core, which checks its own logic; no other dependencies.
`ifndef HALF_DUPLEX_PACKET_LINK_MACROS_SVH
`define HALF_DUPLEX_PACKET_LINK_MACROS_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge outside reset
`define HDPL_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("hdpl check failed");

// Check that a condition implies another in the following cycle
`define HDPL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hdpl check failed");

`else

`define HDPL_ASSERT(label, clk, rst, cond)
`define HDPL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/hdpl_pkg.sv]
// Shared types and constants of the half-duplex packet link.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package hdpl_pkg;

   // Event kinds on the request channel
   typedef enum logic [1:0] {
      FUNC_RX_BYTE = 2'd0,
      FUNC_TX_SLOT = 2'd1,
      FUNC_TX_DONE = 2'd2
   } func_type;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_WORD     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECOVERY_WORD = 2'd1;

   // First payload index after the 4-byte header, and the entry shift of a header byte
   localparam int FIRST_PAYLOAD_INDEX = 4;
   localparam int TOP_BYTE_SHIFT      = 24;

   typedef struct packed {
      func_type    func;
      logic [7:0]  rx_byte;
      logic [7:0]  tx_byte;
   } item_type;

   typedef struct packed {
      logic        sending;
      logic        payload_valid;
      logic [7:0]  payload_index;
      logic [7:0]  payload_data;
      logic        packet_done;
      logic        out_valid;
      logic [7:0]  out_data;
      logic [7:0]  next_tx_index;
      logic        reset_request;
   } result_type;

endpackage

[sv/hdpl_in_stage.sv]
// Input register of the half-duplex packet link: holds one request word.
// Depends on hdpl_pkg for the item type.
`timescale 1ns / 1ps

module hdpl_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // rx_byte [7:0], tx_byte [15:8]
   input  logic [1:0]          req_tuser,   // func [1:0]
   input  logic                take,
   output logic                item_valid,
   output hdpl_pkg::item_type  item
);

   logic               valid_ff;
   logic               valid_in;
   hdpl_pkg::item_type item_ff;
   logic               accept;

   // Accept a new word whenever the held one leaves this cycle or none is held
   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.func    <= hdpl_pkg::func_type'(req_tuser);
         item_ff.rx_byte <= req_tdata[7:0];
         item_ff.tx_byte <= req_tdata[15:8];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[sv/hdpl_core.sv]
// Link state and per-event logic: header shift, sync and recovery compares,
// payload and send position counting, configuration registers. Uses hdpl_pkg.
`timescale 1ns / 1ps
`include "half_duplex_packet_link_macros.svh"

module hdpl_core #(
   parameter int HEAD_PACKET_BYTES = 64,
   parameter int BODY_PACKET_BYTES = 64,
   parameter int POS_W             = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [hdpl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                         csr_data,
   input  logic                                take,
   input  hdpl_pkg::item_type                  item,
   output hdpl_pkg::result_type                result
);

   localparam logic [POS_W-1:0] POS_FIRST = POS_W'(hdpl_pkg::FIRST_PAYLOAD_INDEX);
   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(HEAD_PACKET_BYTES - 1);
   localparam logic [POS_W-1:0] POS_BODY  = POS_W'(BODY_PACKET_BYTES);

   logic [31:0]      sync_word_ff;
   logic [31:0]      recovery_word_ff;
   logic             send_mode_ff;
   logic             send_mode_in;
   logic [31:0]      header_ff;
   logic [31:0]      header_in;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [31:0]      header_shifted;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff     <= '0;
         recovery_word_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            hdpl_pkg::CSR_SYNC_WORD:     sync_word_ff     <= csr_data;
            hdpl_pkg::CSR_RECOVERY_WORD: recovery_word_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // New byte enters the header at the top
   assign header_shifted = (header_ff >> 8)
                         | (32'(item.rx_byte) << hdpl_pkg::TOP_BYTE_SHIFT);

   // Next state and result of the held event
   always_comb begin
      send_mode_in = send_mode_ff;
      header_in    = header_ff;
      pos_in       = pos_ff;
      result       = '0;
      if (!send_mode_ff) begin
         case (item.func)
            hdpl_pkg::FUNC_RX_BYTE: begin
               if (header_ff != sync_word_ff) begin
                  header_in            = header_shifted;
                  result.reset_request = (header_shifted == recovery_word_ff);
               end else begin
                  result.payload_valid = 1'b1;
                  result.payload_index = 8'(pos_ff);
                  result.payload_data  = item.rx_byte;
                  if (pos_ff >= POS_LAST) begin
                     result.packet_done = 1'b1;
                     send_mode_in       = 1'b1;
                     pos_in             = '0;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end else begin
         case (item.func)
            hdpl_pkg::FUNC_TX_SLOT: begin
               if (pos_ff < POS_BODY) begin
                  result.out_valid = 1'b1;
                  result.out_data  = item.tx_byte;
                  pos_in           = pos_ff + 1'b1;
               end
            end
            hdpl_pkg::FUNC_TX_DONE: begin
               // Return to receive only once the whole body is out
               if (pos_ff >= POS_BODY) begin
                  send_mode_in = 1'b0;
                  header_in    = '0;
                  pos_in       = POS_FIRST;
               end
            end
            default: ;
         endcase
      end
      result.sending = send_mode_in;
      if (send_mode_in && (pos_in < POS_BODY)) begin
         result.next_tx_index = 8'(pos_in);
      end
   end

   // Advance state only when the event moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         send_mode_ff <= 1'b0;
         header_ff    <= '0;
         pos_ff       <= POS_FIRST;
      end else if (take) begin
         send_mode_ff <= send_mode_in;
         header_ff    <= header_in;
         pos_ff       <= pos_in;
      end
   end

   `HDPL_ASSERT(a_single_kind, clock, reset, !(result.payload_valid && result.out_valid))
   `HDPL_ASSERT(a_send_bound, clock, reset, !send_mode_ff || (pos_ff <= POS_BODY))
   `HDPL_ASSERT(a_recv_bound, clock, reset,
      send_mode_ff || ((pos_ff >= POS_FIRST) && (pos_ff <= POS_LAST)))
   `HDPL_ASSERT(a_recv_no_out, clock, reset, send_mode_ff || !result.out_valid)
   `HDPL_ASSERT_NEXT(a_done_to_send, clock, reset, take && result.packet_done,
      send_mode_ff && (pos_ff == '0))

endmodule

[sv/hdpl_out_stage.sv]
// Result register of the half-duplex packet link, driving the response port.
// Depends on hdpl_pkg for the result type.
`timescale 1ns / 1ps

module hdpl_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  hdpl_pkg::result_type  result,
   output logic                  can_load,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,  // payload_index [7:0], payload_data [15:8],
                                             // out_data [23:16], next_tx_index [31:24]
   output logic [3:0]            rsp_tuser,  // sending [0], payload_valid [1],
                                             // out_valid [2], reset_request [3]
   output logic                  rsp_tlast   // packet_done
);

   logic                 valid_ff;
   logic                 valid_in;
   hdpl_pkg::result_type result_ff;

   // Take a new word when empty or when the held one is being taken
   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   // Pack the port
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {result_ff.next_tx_index, result_ff.out_data,
                        result_ff.payload_data, result_ff.payload_index};
   assign rsp_tuser  = {result_ff.reset_request, result_ff.out_valid,
                        result_ff.payload_valid, result_ff.sending};
   assign rsp_tlast  = result_ff.packet_done;

endmodule

[sv/half_duplex_packet_link.sv]
// Half-duplex packet link: each request word is one event (received byte,
// free transmit slot, or transmission complete) and yields exactly one response
// word. A word is accepted every cycle while the response side keeps up. It
// passes the input register, then the result register, from which its response
// word is offered on the response port. The only thing that slows intake is a
// stalled response port. Configuration writes are taken in every cycle and
// apply to events processed afterwards. Depends on hdpl_pkg, hdpl_in_stage,
// hdpl_core and hdpl_out_stage.
`timescale 1ns / 1ps

module half_duplex_packet_link #(
   parameter int HEAD_PACKET_BYTES = 64,
   parameter int BODY_PACKET_BYTES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // rx_byte [7:0], tx_byte [15:8]
   input  logic [1:0]                        req_tuser,   // func [1:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,   // payload_index [7:0],
                                                          // payload_data [15:8],
                                                          // out_data [23:16],
                                                          // next_tx_index [31:24]
   output logic [3:0]                        rsp_tuser,   // sending [0], payload_valid [1],
                                                          // out_valid [2], reset_request [3]
   output logic                              rsp_tlast,   // packet_done
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hdpl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                       csr_data
);

   // Position counter holds payload indices below the head size and send counts up to the body size
   localparam int POS_MAX = (HEAD_PACKET_BYTES > BODY_PACKET_BYTES) ?
                            HEAD_PACKET_BYTES : BODY_PACKET_BYTES;
   localparam int POS_W   = $clog2(POS_MAX + 1);

   logic                 item_valid;
   logic                 take;
   logic                 can_load;
   hdpl_pkg::item_type   item;
   hdpl_pkg::result_type result;

   assign csr_ready = 1'b1;

   // Advance the held event when the result register can take its word
   assign take = item_valid && can_load;

   hdpl_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   hdpl_core #(
      .HEAD_PACKET_BYTES (HEAD_PACKET_BYTES),
      .BODY_PACKET_BYTES (BODY_PACKET_BYTES),
      .POS_W             (POS_W)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .take      (take),
      .item      (item),
      .result    (result)
   );

   hdpl_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[verif/half_duplex_packet_link_tb.sv]
// Self-checking testbench for the half-duplex packet link controller.
// Depends on hdpl_pkg and half_duplex_packet_link; predicts every response word
// from its own model of the link and checks it field by field.
`timescale 1ns / 1ps

module half_duplex_packet_link_tb;

   localparam int HEAD_BYTES = 64;
   localparam int BODY_BYTES = 64;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 4;

   // Event kind that the block has no use for
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] rx;
      logic [7:0] tx;
   } link_event_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // rx_byte [7:0], tx_byte [15:8]
   logic [1:0]  req_tuser;   // func [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // payload_index [7:0], payload_data [15:8],
                             // out_data [23:16], next_tx_index [31:24]
   logic [3:0]  rsp_tuser;   // sending [0], payload_valid [1], out_valid [2],
                             // reset_request [3]
   logic        rsp_tlast;   // packet_done
   logic        csr_valid;
   logic        csr_ready;
   logic [hdpl_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [31:0] csr_data;

   half_duplex_packet_link #(
      .HEAD_PACKET_BYTES (HEAD_BYTES),
      .BODY_PACKET_BYTES (BODY_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   link_event_type       pending_events[$];
   hdpl_pkg::result_type expected_results[$];
   int         queued_count = 0;
   int         error_count = 0;
   int         idle_cycles = 0;
   bit         req_fire = 1'b0;

   // Predicted link state and register copies
   logic        link_sending;
   logic [31:0] link_header;
   logic [8:0]  link_position;
   logic [31:0] cfg_sync;
   logic [31:0] cfg_recovery;

   // Work out the response word of one event and advance the predicted state
   function automatic hdpl_pkg::result_type predict_link_event(link_event_type ev);
      hdpl_pkg::result_type r;
      r = '0;
      if (!link_sending) begin
         if (ev.kind == hdpl_pkg::FUNC_RX_BYTE) begin
            if (link_header != cfg_sync) begin
               link_header = {ev.rx, link_header[31:8]};
               r.reset_request = (link_header == cfg_recovery);
            end else begin
               r.payload_valid = 1'b1;
               r.payload_index = link_position[7:0];
               r.payload_data  = ev.rx;
               if (link_position >= HEAD_BYTES - 1) begin
                  r.packet_done = 1'b1;
                  link_sending  = 1'b1;
                  link_position = '0;
               end else begin
                  link_position = link_position + 1'b1;
               end
            end
         end
      end else if (ev.kind == hdpl_pkg::FUNC_TX_SLOT) begin
         if (link_position < BODY_BYTES) begin
            r.out_valid   = 1'b1;
            r.out_data    = ev.tx;
            link_position = link_position + 1'b1;
         end
      end else if (ev.kind == hdpl_pkg::FUNC_TX_DONE) begin
         // Completion only counts once the whole body packet is out
         if (link_position >= BODY_BYTES) begin
            link_sending  = 1'b0;
            link_header   = '0;
            link_position = 9'(hdpl_pkg::FIRST_PAYLOAD_INDEX);
         end
      end
      if (link_sending && link_position < BODY_BYTES)
         r.next_tx_index = link_position[7:0];
      r.sending = link_sending;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // Monitor: check response words, predict accepted requests, watch for a hang
   always @(posedge clock) begin
      hdpl_pkg::result_type want;
      link_event_type       ev;
      bit                   rsp_fire;
      req_fire = req_tvalid && req_tready;
      rsp_fire = rsp_tvalid && rsp_tready;
      if (reset) begin
         link_sending  = 1'b0;
         link_header   = '0;
         link_position = 9'(hdpl_pkg::FIRST_PAYLOAD_INDEX);
         cfg_sync      = '0;
         cfg_recovery  = '0;
         idle_cycles   = 0;
      end else begin
         if (rsp_fire) begin
            if (expected_results.size() == 0) begin
               $error("response word with no request pending: tdata %0h tuser %0h",
                      rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("sending", 8'(want.sending), 8'(rsp_tuser[0]));
               check_field("payload_valid", 8'(want.payload_valid), 8'(rsp_tuser[1]));
               check_field("payload_index", want.payload_index, rsp_tdata[7:0]);
               check_field("payload_data", want.payload_data, rsp_tdata[15:8]);
               check_field("packet_done", 8'(want.packet_done), 8'(rsp_tlast));
               check_field("out_valid", 8'(want.out_valid), 8'(rsp_tuser[2]));
               check_field("out_data", want.out_data, rsp_tdata[23:16]);
               check_field("next_tx_index", want.next_tx_index, rsp_tdata[31:24]);
               check_field("reset_request", 8'(want.reset_request), 8'(rsp_tuser[3]));
            end
         end
         if (req_fire) begin
            ev.kind = req_tuser;
            ev.rx   = req_tdata[7:0];
            ev.tx   = req_tdata[15:8];
            expected_results.push_back(predict_link_event(ev));
         end
         if (req_fire || rsp_fire || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Sender: bursts of random length with random gaps between them
   int burst_left = 1;
   int gap_left = 0;

   always @(negedge clock) begin
      link_event_type ev;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_fire || !req_tvalid) begin
         if (gap_left != 0 || pending_events.size() == 0) begin
            req_tvalid <= 1'b0;
            if (gap_left != 0)
               gap_left--;
         end else begin
            ev = pending_events.pop_front();
            req_tuser  <= ev.kind;
            req_tdata  <= {ev.tx, ev.rx};
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // Receiver: ready pattern that switches between randomly chosen stall modes
   int stall_mode = 0;
   int stall_left = 0;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 96);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 2) == 0);
         default: rsp_tready <= stall_left[2];
      endcase
   end

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_event(input logic [1:0] kind, input logic [7:0] rx,
                              input logic [7:0] tx);
      link_event_type ev;
      ev.kind = kind;
      ev.rx   = rx;
      ev.tx   = tx;
      pending_events.push_back(ev);
      queued_count++;
   endtask

   // Event that the current mode has to ignore, or an unused kind
   task automatic queue_stray(input bit in_send);
      case ($urandom_range(0, 2))
         0: queue_event(FUNC_UNUSED, rand_byte(), rand_byte());
         1: queue_event(in_send ? hdpl_pkg::FUNC_RX_BYTE : hdpl_pkg::FUNC_TX_SLOT,
                        rand_byte(), rand_byte());
         default: queue_event(hdpl_pkg::FUNC_TX_DONE, rand_byte(), rand_byte());
      endcase
   endtask

   // Full exchange: sync header, head payload, body send, then completion
   task automatic queue_packet();
      int extra;
      for (int b = 0; b < 4; b++)
         queue_event(hdpl_pkg::FUNC_RX_BYTE, cfg_sync[8*b +: 8], rand_byte());
      for (int i = hdpl_pkg::FIRST_PAYLOAD_INDEX; i < HEAD_BYTES; i++) begin
         if ($urandom_range(0, 11) == 0)
            queue_stray(1'b0);
         queue_event(hdpl_pkg::FUNC_RX_BYTE, rand_byte(), rand_byte());
      end
      for (int i = 0; i < BODY_BYTES; i++) begin
         if ($urandom_range(0, 11) == 0)
            queue_stray(1'b1);
         queue_event(hdpl_pkg::FUNC_TX_SLOT, rand_byte(), rand_byte());
      end
      // Slots past the last body byte send nothing
      extra = $urandom_range(0, 2);
      repeat (extra) queue_event(hdpl_pkg::FUNC_TX_SLOT, rand_byte(), rand_byte());
      queue_event(hdpl_pkg::FUNC_TX_DONE, rand_byte(), rand_byte());
   endtask

   // Short run of loose events: recovery word, partial sync, or random kinds
   task automatic queue_noise();
      int n;
      case ($urandom_range(0, 3))
         0: begin
            for (int b = 0; b < 4; b++)
               queue_event(hdpl_pkg::FUNC_RX_BYTE, cfg_recovery[8*b +: 8], rand_byte());
         end
         1: begin
            n = $urandom_range(1, 3);
            for (int b = 0; b < n; b++)
               queue_event(hdpl_pkg::FUNC_RX_BYTE, cfg_sync[8*b +: 8], rand_byte());
            queue_event(hdpl_pkg::FUNC_RX_BYTE, rand_byte(), rand_byte());
         end
         default: begin
            n = $urandom_range(1, 10);
            repeat (n) begin
               if ($urandom_range(0, 3) == 0)
                  queue_event(2'($urandom_range(1, 3)), rand_byte(), rand_byte());
               else
                  queue_event(hdpl_pkg::FUNC_RX_BYTE, rand_byte(), rand_byte());
            end
         end
      endcase
   endtask

   task automatic queue_phase(input int target);
      int start;
      start = queued_count;
      queue_noise();
      queue_packet();
      while (queued_count - start < target) begin
         if ($urandom_range(0, 2) == 0)
            queue_packet();
         else
            queue_noise();
      end
   endtask

   // Hold until every word is out and answered, then let the pipeline settle
   task automatic wait_idle();
      while (pending_events.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [hdpl_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] value);
      @(negedge clock);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == hdpl_pkg::CSR_SYNC_WORD)
         cfg_sync = value;
      else
         cfg_recovery = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [31:0] shared_word;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b1;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Send-side and unused events in receive mode are ignored
      queue_event(hdpl_pkg::FUNC_TX_SLOT, 8'hFF, 8'hFF);
      queue_event(hdpl_pkg::FUNC_TX_DONE, 8'h00, 8'h00);
      queue_event(FUNC_UNUSED, 8'hFF, 8'hFF);
      wait_idle();

      write_reg(hdpl_pkg::CSR_SYNC_WORD, 32'hFFFF_FFFF);
      write_reg(hdpl_pkg::CSR_RECOVERY_WORD, 32'h0000_0000);
      // Zero bytes hit the recovery word; four 0xFF bytes reach sync
      queue_event(hdpl_pkg::FUNC_RX_BYTE, 8'h00, 8'hFF);
      queue_event(hdpl_pkg::FUNC_RX_BYTE, 8'h00, 8'h00);
      repeat (4) queue_event(hdpl_pkg::FUNC_RX_BYTE, 8'hFF, 8'h00);
      queue_event(hdpl_pkg::FUNC_RX_BYTE, 8'h00, 8'hFF);
      queue_event(hdpl_pkg::FUNC_TX_SLOT, 8'h00, 8'hFF);
      queue_event(hdpl_pkg::FUNC_TX_DONE, 8'hFF, 8'h00);
      queue_event(FUNC_UNUSED, 8'h00, 8'h00);
      queue_event(hdpl_pkg::FUNC_RX_BYTE, 8'hFF, 8'h00);
      // Rest of the open packet, then its send side
      queue_packet();
      wait_idle();

      // Sync at zero: a cleared header already matches it
      write_reg(hdpl_pkg::CSR_SYNC_WORD, 32'h0000_0000);
      write_reg(hdpl_pkg::CSR_RECOVERY_WORD, 32'hFFFF_FFFF);
      queue_phase(100);
      wait_idle();

      // Sync and recovery share one random value
      shared_word = $urandom;
      write_reg(hdpl_pkg::CSR_SYNC_WORD, shared_word);
      write_reg(hdpl_pkg::CSR_RECOVERY_WORD, shared_word);
      queue_phase(100);
      wait_idle();

      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/hdpl_pkg.sv
sv/hdpl_in_stage.sv
sv/hdpl_core.sv
sv/hdpl_out_stage.sv
sv/half_duplex_packet_link.sv
verif/half_duplex_packet_link_tb.sv
